// File: sv/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants of the run-length byte decompressor: the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 32;

    localparam int BYTE_W      = 8;
    localparam int NV_W        = 2;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    // header decoding
    localparam logic [7:0] HDR_RUN_FLAG = 8'h80;
    localparam logic [7:0] HDR_CNT_MASK = 8'h7F;

    // bytes_valid codes
    localparam logic [1:0] NV_NONE = 2'd0;
    localparam logic [1:0] NV_ONE  = 2'd1;
    localparam logic [1:0] NV_TWO  = 2'd2;

    typedef enum logic [1:0] {
        OUT_EMPTY = 2'd0,
        OUT_RUN   = 2'd1,
        OUT_LIT   = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic      hdr_load;   // latch run length / literal count from header
        logic      run_start;  // run data byte arrives, add run length to count
        logic      lit_take;   // literal byte passes, add one to count
        logic      fin_load;   // remember the final flag of the run data byte
        logic      out_load;   // load the output register
        out_kind_t out_kind;
        logic      out_last;
        logic      out_done;
        logic      out_trunc;
        logic      clear;      // stream closed, length counter back to zero
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_is_run;
        logic hdr_is_lit;
        logic run_len_short;   // whole run fits in one item
        logic run_rem_short;   // remaining run fits in one item
        logic lit_last;        // this literal byte ends the packet
        logic fin_pending;     // run being expanded ends the stream
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/rle_datapath.sv
// ----------------------------------------------------------------------------
// rle_datapath
// Packet counters, saturating length counter and the output register of
// the run-length decompressor, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_datapath #(
    parameter int LENGTH_WIDTH = rle_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    input  wire rle_pkg::dp_cmd_t     cmd,
    output rle_pkg::dp_status_t       status,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [7:0]                out_first,
    output logic [7:0]                out_second,
    output logic [1:0]                out_nv,
    output logic                      out_last,
    output logic                      out_done,
    output logic [31:0]               out_total,
    output logic                      out_trunc
);

    logic [7:0]              run_length_reg;
    logic [7:0]              run_rem_reg;
    logic [7:0]              run_byte_reg;
    logic [6:0]              lit_rem_reg;
    logic                    fin_reg;
    logic [LENGTH_WIDTH-1:0] count_reg;
    logic [LENGTH_WIDTH-1:0] count_next;

    logic                    out_valid_reg;
    logic [7:0]              out_first_reg;
    logic [7:0]              out_second_reg;
    logic [1:0]              out_nv_reg;
    logic                    out_last_reg;
    logic                    out_done_reg;
    logic [31:0]             out_total_reg;
    logic                    out_trunc_reg;

    logic [7:0]              rem_sel;
    logic [7:0]              run_data;
    logic [7:0]              add_amt;
    logic [LENGTH_WIDTH:0]   count_sum;
    logic [31:0]             total32;

    logic [7:0]              first_d;
    logic [7:0]              second_d;
    logic [1:0]              nv_d;

    assign rem_sel  = cmd.run_start ? run_length_reg : run_rem_reg;
    assign run_data = cmd.run_start ? in_byte : run_byte_reg;

    always_comb
    begin
        add_amt = 8'd0;
        if (cmd.run_start)
        begin
            add_amt = run_length_reg;
        end
        else if (cmd.lit_take)
        begin
            add_amt = 8'd1;
        end
    end

    // saturating add into the length counter
    assign count_sum  = {1'b0, count_reg} + (LENGTH_WIDTH+1)'(add_amt);
    assign count_next = count_sum[LENGTH_WIDTH] ? {LENGTH_WIDTH{1'b1}}
                                                : count_sum[LENGTH_WIDTH-1:0];

    generate
        if (LENGTH_WIDTH > 32)
        begin : g_total_sat
            assign total32 = (|count_next[LENGTH_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                              : count_next[31:0];
        end
        else if (LENGTH_WIDTH == 32)
        begin : g_total_eq
            assign total32 = count_next;
        end
        else
        begin : g_total_ext
            assign total32 = {{(32-LENGTH_WIDTH){1'b0}}, count_next};
        end
    endgenerate

    always_comb
    begin
        first_d  = 8'd0;
        second_d = 8'd0;
        nv_d     = rle_pkg::NV_NONE;
        case (cmd.out_kind)
            rle_pkg::OUT_RUN:
            begin
                first_d = run_data;
                if (rem_sel >= 8'd2)
                begin
                    second_d = run_data;
                    nv_d     = rle_pkg::NV_TWO;
                end
                else
                begin
                    nv_d = rle_pkg::NV_ONE;
                end
            end
            rle_pkg::OUT_LIT:
            begin
                first_d = in_byte;
                nv_d    = rle_pkg::NV_ONE;
            end
            default:
            begin
                first_d = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.run_start || cmd.lit_take)
            begin
                count_reg <= count_next;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_load)
        begin
            run_length_reg <= {1'b0, in_byte[6:0] & rle_pkg::HDR_CNT_MASK[6:0]} + 8'd1;
            lit_rem_reg    <= in_byte[6:0] & rle_pkg::HDR_CNT_MASK[6:0];
        end
        else if (cmd.lit_take && (lit_rem_reg != 7'd0))
        begin
            lit_rem_reg <= lit_rem_reg - 7'd1;
        end

        if (cmd.run_start)
        begin
            run_byte_reg <= in_byte;
        end
        if (cmd.fin_load)
        begin
            fin_reg <= in_last;
        end
        if (cmd.out_load && (cmd.out_kind == rle_pkg::OUT_RUN))
        begin
            run_rem_reg <= rem_sel - 8'd2;
        end

        if (cmd.out_load)
        begin
            out_first_reg  <= first_d;
            out_second_reg <= second_d;
            out_nv_reg     <= nv_d;
            out_last_reg   <= cmd.out_last;
            out_done_reg   <= cmd.out_done;
            out_total_reg  <= cmd.out_done ? total32 : 32'd0;
            out_trunc_reg  <= cmd.out_done & cmd.out_trunc;
        end
    end

    always_comb
    begin
        status.hdr_is_run    = (in_byte & rle_pkg::HDR_RUN_FLAG) == rle_pkg::HDR_RUN_FLAG;
        status.hdr_is_lit    = !status.hdr_is_run &&
                               ((in_byte & rle_pkg::HDR_CNT_MASK) != 8'd0);
        status.run_len_short = run_length_reg <= 8'd2;
        status.run_rem_short = run_rem_reg <= 8'd2;
        status.lit_last      = lit_rem_reg <= 7'd1;
        status.fin_pending   = fin_reg;
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_nv     = out_nv_reg;
    assign out_last   = out_last_reg;
    assign out_done   = out_done_reg;
    assign out_total  = out_total_reg;
    assign out_trunc  = out_trunc_reg;

    // a waiting item is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten while stalled");

    // closing item is always the last item of its input
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("stream closed on an item that is not last of its input");

    // closing the stream returns the counter to zero
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0))
        else $error("length counter not cleared at end of stream");

    a_nv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_nv_reg != 2'd3))
        else $error("bytes_valid out of range");

endmodule

`default_nettype wire

// File: sv/rle_controller.sv
// ----------------------------------------------------------------------------
// rle_controller
// Packet state machine of the run-length decompressor: parses headers,
// steps through literals and expands runs two bytes per item.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    input  wire rle_pkg::dp_status_t  status,
    output rle_pkg::dp_cmd_t          cmd
);

    typedef enum logic [3:0] {
        ST_HEADER   = 4'b0001,
        ST_RUN_BYTE = 4'b0010,
        ST_LITERAL  = 4'b0100,
        ST_EXPAND   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg != ST_EXPAND) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_HEADER:
            begin
                if (accept)
                begin
                    cmd.hdr_load = 1'b1;
                    if (in_last)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = rle_pkg::OUT_EMPTY;
                        cmd.out_last  = 1'b1;
                        cmd.out_done  = 1'b1;
                        cmd.out_trunc = status.hdr_is_run || status.hdr_is_lit;
                        cmd.clear     = 1'b1;
                    end
                    else if (status.hdr_is_run)
                    begin
                        state_next = ST_RUN_BYTE;
                    end
                    else if (status.hdr_is_lit)
                    begin
                        state_next = ST_LITERAL;
                    end
                end
            end
            ST_RUN_BYTE:
            begin
                if (accept)
                begin
                    cmd.run_start = 1'b1;
                    cmd.fin_load  = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = rle_pkg::OUT_RUN;
                    cmd.out_last  = status.run_len_short;
                    cmd.out_done  = status.run_len_short && in_last;
                    if (status.run_len_short)
                    begin
                        cmd.clear  = in_last;
                        state_next = ST_HEADER;
                    end
                    else
                    begin
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_LITERAL:
            begin
                if (accept)
                begin
                    cmd.lit_take  = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = rle_pkg::OUT_LIT;
                    cmd.out_last  = 1'b1;
                    cmd.out_done  = in_last;
                    cmd.out_trunc = !status.lit_last;
                    cmd.clear     = in_last;
                    if (in_last || status.lit_last)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            ST_EXPAND:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = rle_pkg::OUT_RUN;
                    cmd.out_last = status.run_rem_short;
                    cmd.out_done = status.run_rem_short && status.fin_pending;
                    if (status.run_rem_short)
                    begin
                        cmd.clear  = status.fin_pending;
                        state_next = ST_HEADER;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a final input always leaves the parser expecting a header or expanding
    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last && (state_reg != ST_RUN_BYTE)) |=> (state_reg == ST_HEADER))
        else $error("final input did not return to header phase");

    // expansion only starts from a run data byte
    a_expand_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EXPAND) |-> $past(cmd.run_start))
        else $error("expansion entered without a run data byte");

    a_clear_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.out_load && cmd.out_done))
        else $error("state cleared without closing item");

endmodule

`default_nettype wire

// File: sv/rle_byte_decompressor_core.sv
// ----------------------------------------------------------------------------
// rle_byte_decompressor_core
// Run-length byte decompressor: headers and data bytes in, up to two
// decoded bytes per item out, with stream length and truncation report.
// ----------------------------------------------------------------------------
// Takes one compressed byte per item. A header byte with bit 7 set repeats
// the next byte (low seven bits + 1) times; with bit 7 clear it passes the
// next (low seven bits) bytes through, zero being a no-op. Headers and
// literal bytes are taken one per cycle while the output register is free
// or draining; a header item gives no result unless it ends the stream. A
// run data byte of an n-byte run loads its first result into the output
// register when it is taken and then stalls the input until the run is
// expanded, since the expansion counter emits two bytes per cycle while the
// single output register is free. The item marked tlast closes the stream:
// its final result carries stream_done, the saturated decoded length and
// the truncation flag, and the length counter and parser state return to reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_byte_decompressor_core #(
    parameter int LENGTH_WIDTH = rle_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // in_byte
    input  wire logic [rle_pkg::IN_TDATA_W-1:0]    in_tdata,
    // is_final
    input  wire logic                              in_tlast,
    input  wire logic                              in_tvalid,
    output logic                                   in_tready,
    // data_first, data_second, bytes_valid, total_length, zero pad
    output logic [rle_pkg::OUT_TDATA_W-1:0]        out_tdata,
    // last_of_input
    output logic                                   out_tlast,
    // stream_done, truncated
    output logic [rle_pkg::OUT_TUSER_W-1:0]        out_tuser,
    output logic                                   out_tvalid,
    input  wire logic                              out_tready
);

    rle_pkg::dp_cmd_t    cmd;
    rle_pkg::dp_status_t status;

    logic [7:0]  out_first;
    logic [7:0]  out_second;
    logic [1:0]  out_nv;
    logic        out_done;
    logic [31:0] out_total;
    logic        out_trunc;

    rle_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_tvalid),
        .in_last  (in_tlast),
        .in_ready (in_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rle_datapath #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_tdata[7:0]),
        .in_last    (in_tlast),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_tready),
        .out_valid  (out_tvalid),
        .out_first  (out_first),
        .out_second (out_second),
        .out_nv     (out_nv),
        .out_last   (out_tlast),
        .out_done   (out_done),
        .out_total  (out_total),
        .out_trunc  (out_trunc)
    );

    assign out_tdata = {6'd0, out_total, out_nv, out_second, out_first};
    assign out_tuser = {out_trunc, out_done};

endmodule

`default_nettype wire
